>>> src/whc_pkg.sv
// ----------------------------------------------------------------------------
// whc_pkg: shared types and constants of the weighted coverage histogram
// Holds the queue entry layout, the opcode and status codes, and the
// default sizes used by the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package whc_pkg;

   // Bin store depth by default and widest bin index over the legal range
   localparam int BIN_COUNT_DEFAULT = 2048;
   localparam int BIN_W_MAX         = 16;

   // Field widths fixed by the interface
   localparam int POS_W    = 32;
   localparam int COV_W    = 16;
   localparam int IDX11_W  = 11;
   localparam int COUNT_W  = 63;
   localparam int WEIGHT_W = POS_W + 1;

   // Top bin floor after reset
   localparam logic [IDX11_W-1:0] TOP_BIN_FLOOR_RESET = 11'd1000;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CLAMPED   = 2'd1,
      STATUS_REVERSED  = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   // One classified item on its way from the front to the back
   typedef struct packed {
      logic                 is_add;
      logic [BIN_W_MAX-1:0] bin;
      logic [WEIGHT_W-1:0]  weight;
      logic [IDX11_W-1:0]   top_bin;
      status_type           status;
   } entry_type;

endpackage

`default_nettype wire

>>> src/whc_ram.sv
// ----------------------------------------------------------------------------
// whc_ram: generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/whc_front.sv
// ----------------------------------------------------------------------------
// whc_front: item intake and classification
// Takes items, clamps the bin, finds the interval weight and the reversed
// case, tracks the highest bin seen and the top bin floor, and pushes one
// classified entry per item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_front #(
   parameter int BIN_COUNT = whc_pkg::BIN_COUNT_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic                         req_opcode,
   input  wire logic [whc_pkg::POS_W-1:0]    req_start_pos,
   input  wire logic [whc_pkg::POS_W-1:0]    req_end_pos,
   input  wire logic [whc_pkg::COV_W-1:0]    req_coverage,
   input  wire logic [whc_pkg::IDX11_W-1:0]  req_read_bin,
   input  wire logic                         csr_write_enable,
   input  wire logic [whc_pkg::IDX11_W-1:0]  csr_write_data,
   input  wire logic                         clear_busy,
   input  wire logic                         q_full,
   output logic                              q_push,
   output whc_pkg::entry_type                q_entry
);

   import whc_pkg::*;

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam int CMP_W = BIN_W_MAX + 1;
   localparam logic [CMP_W-1:0] LAST_BIN = CMP_W'(BIN_COUNT - 1);

   logic [IDX11_W-1:0]   floor_ff;
   logic [IDX_W-1:0]     highest_ff;
   logic [IDX_W-1:0]     highest_in;
   logic                 accept;
   logic                 is_add;
   logic [CMP_W-1:0]     level;
   logic                 clamped;
   logic [BIN_W_MAX-1:0] bin;
   logic [IDX_W-1:0]     bin_idx;
   logic                 reversed;
   logic [CMP_W-1:0]     top_wide;
   status_type           status;

   // Hold off intake while the store is being cleared or the queue is full
   assign req_full = clear_busy | q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = accept;

   // Clamp the selected level into the store
   always_comb begin
      is_add = (opcode_type'(req_opcode) == OP_ADD);
      if (is_add) begin
         level = {1'b0, req_coverage};
      end else begin
         level = {(CMP_W - IDX11_W)'(0), req_read_bin};
      end
      clamped = (level > LAST_BIN);
      bin     = clamped ? LAST_BIN[BIN_W_MAX-1:0] : level[BIN_W_MAX-1:0];
      bin_idx = bin[IDX_W-1:0];
   end

   // Track the highest bin touched by an add
   always_comb begin
      highest_in = highest_ff;
      if (accept && is_add && (bin_idx > highest_ff)) begin
         highest_in = bin_idx;
      end
   end

   // Top bin with this item counted, capped at the last bin
   always_comb begin
      logic [IDX_W-1:0] high_now;
      high_now = (is_add && (bin_idx > highest_ff)) ? bin_idx : highest_ff;
      if ({(CMP_W - IDX11_W)'(0), floor_ff} > {(CMP_W - IDX_W)'(0), high_now}) begin
         top_wide = {(CMP_W - IDX11_W)'(0), floor_ff};
      end else begin
         top_wide = {(CMP_W - IDX_W)'(0), high_now};
      end
      if (top_wide > LAST_BIN) begin
         top_wide = LAST_BIN;
      end
   end

   // Classify the item
   always_comb begin
      reversed = is_add && (req_end_pos < req_start_pos);
      if (reversed) begin
         status = STATUS_REVERSED;
      end else if (clamped) begin
         status = STATUS_CLAMPED;
      end else begin
         status = STATUS_OK;
      end
      q_entry.is_add  = is_add & ~reversed;
      q_entry.bin     = bin;
      q_entry.weight  = {1'b0, req_end_pos} - {1'b0, req_start_pos} + WEIGHT_W'(1);
      q_entry.top_bin = top_wide[IDX11_W-1:0];
      q_entry.status  = status;
   end

   // Floor register and highest bin seen
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= TOP_BIN_FLOOR_RESET;
         highest_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            floor_ff <= csr_write_data;
         end
         highest_ff <= highest_in;
      end
   end

endmodule

`default_nettype wire

>>> src/whc_queue.sv
// ----------------------------------------------------------------------------
// whc_queue: two-entry queue between front and back
// Decouples intake from the read-modify-write of the bin store.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  whc_pkg::entry_type push_entry,
   output logic               full,
   input  wire logic          pop,
   output whc_pkg::entry_type head,
   output logic               empty
);

   import whc_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slot_ff[rd_ptr_ff];

   // Next fill level
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/whc_back.sv
// ----------------------------------------------------------------------------
// whc_back: bin store read-modify-write and result register
// Clears the bin store after reset, then for each queued item reads the
// bin and, for an add, adds the weight with saturation and writes it back,
// then presents the result.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_back #(
   parameter int BIN_COUNT = whc_pkg::BIN_COUNT_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  whc_pkg::entry_type                q_head,
   input  wire logic                         q_empty,
   output logic                              q_pop,
   output logic                              clear_busy,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic      [whc_pkg::IDX11_W-1:0]  rsp_bin_index,
   output logic      [whc_pkg::COUNT_W-1:0]  rsp_bin_count,
   output logic      [whc_pkg::IDX11_W-1:0]  rsp_top_bin,
   output logic      [1:0]                   rsp_status
);

   import whc_pkg::*;

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_ISSUE = 3'b010,
      ST_CALC  = 3'b100
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [IDX_W-1:0]   clear_ff;
   logic [IDX_W-1:0]   clear_in;
   logic               valid_ff;
   logic               valid_in;
   logic [IDX11_W-1:0] bin_index_ff;
   logic [COUNT_W-1:0] bin_count_ff;
   logic [IDX11_W-1:0] top_bin_ff;
   status_type         status_ff;

   logic               out_free;
   logic               finish;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [COUNT_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [COUNT_W-1:0] ram_rd_data;
   logic [COUNT_W:0]   sum;
   logic               saturated;
   logic [COUNT_W-1:0] new_count;
   status_type         new_status;

   whc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (BIN_COUNT)
   ) u_bin_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (q_head.bin[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign clear_busy = (state_ff == ST_CLEAR);
   assign out_free   = ~valid_ff | rsp_pop;
   assign finish     = (state_ff == ST_CALC) && out_free;
   assign q_pop      = finish;

   // Saturating add of the weight
   always_comb begin
      sum       = {1'b0, ram_rd_data} + {(COUNT_W + 1 - WEIGHT_W)'(0), q_head.weight};
      saturated = q_head.is_add & sum[COUNT_W];
      if (!q_head.is_add) begin
         new_count = ram_rd_data;
      end else if (saturated) begin
         new_count = '1;
      end else begin
         new_count = sum[COUNT_W-1:0];
      end
      new_status = saturated ? STATUS_SATURATED : q_head.status;
   end

   // Store write: zeros while clearing, updated count on an add
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = finish & q_head.is_add;
         ram_wr_addr = q_head.bin[IDX_W-1:0];
         ram_wr_data = new_count;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      clear_in  = clear_ff;
      ram_rd_en = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + IDX_W'(1);
            if (clear_ff == LAST_IDX) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (!q_empty) begin
               ram_rd_en = 1'b1;
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            if (out_free) begin
               state_in = ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Result valid
   always_comb begin
      valid_in = valid_ff;
      if (finish) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         valid_ff <= valid_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (finish) begin
         bin_index_ff <= q_head.bin[IDX11_W-1:0];
         bin_count_ff <= new_count;
         top_bin_ff   <= q_head.top_bin;
         status_ff    <= new_status;
      end
   end

   assign rsp_empty     = ~valid_ff;
   assign rsp_bin_index = bin_index_ff;
   assign rsp_bin_count = bin_count_ff;
   assign rsp_top_bin   = top_bin_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

>>> src/weighted_coverage_histogram_unit.sv
// ----------------------------------------------------------------------------
// weighted_coverage_histogram_unit: weighted histogram of coverage levels
// Front, queue and back joined into the complete block.
// ----------------------------------------------------------------------------
// Each add item with end_pos not below start_pos adds end_pos - start_pos + 1
// to the bin of its coverage level, and each read item returns one bin's count;
// every item gives one result with the bin, its count, the top bin in use and
// a status code. After reset the block clears every word of its bin store and
// shows full during that pass. After that the back reads the bin of an item
// from the store RAM, then adds, writes back and loads the result register,
// stalling there while the old result waits to be popped. The back takes a new
// item only when it is through with the last one. A two-entry queue sits
// between intake and the back, and intake goes on while a result waits to be
// popped. Write the floor register only while the block is idle.
`default_nettype none

module weighted_coverage_histogram_unit #(
   parameter int BIN_COUNT = whc_pkg::BIN_COUNT_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic                         req_opcode,
   input  wire logic [whc_pkg::POS_W-1:0]    req_start_pos,
   input  wire logic [whc_pkg::POS_W-1:0]    req_end_pos,
   input  wire logic [whc_pkg::COV_W-1:0]    req_coverage,
   input  wire logic [whc_pkg::IDX11_W-1:0]  req_read_bin,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic      [whc_pkg::IDX11_W-1:0]  rsp_bin_index,
   output logic      [whc_pkg::COUNT_W-1:0]  rsp_bin_count,
   output logic      [whc_pkg::IDX11_W-1:0]  rsp_top_bin,
   output logic      [1:0]                   rsp_status,
   input  wire logic                         csr_write_enable,
   input  wire logic [whc_pkg::IDX11_W-1:0]  csr_write_data
);

   import whc_pkg::*;

   entry_type q_in_entry;
   entry_type q_head;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   logic      clear_busy;

   // Classify items
   whc_front #(
      .BIN_COUNT (BIN_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_start_pos    (req_start_pos),
      .req_end_pos      (req_end_pos),
      .req_coverage     (req_coverage),
      .req_read_bin     (req_read_bin),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .clear_busy       (clear_busy),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_in_entry)
   );

   // Buffer classified items
   whc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   // Update the store and deliver results
   whc_back #(
      .BIN_COUNT (BIN_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .clear_busy    (clear_busy),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_count (rsp_bin_count),
      .rsp_top_bin   (rsp_top_bin),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire
